// ===== hw/rtl/vna_pkg.sv =====
// shared types and codes for the vertex normal accumulator
package vna_pkg;

    // item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_FACE  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // accumulator and normal widths
    localparam int SUM_W = 28;
    localparam int NRM_W = 16;

    // register index of vertex_count
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic        [1:0]  mode;
        logic        [9:0]  vertex_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic        [9:0]  corner_a;
        logic        [9:0]  corner_b;
        logic        [9:0]  corner_c;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic        [1:0]  status;
    } t_rsp;

    // vector handed to the unit vector engine
    typedef struct packed {
        logic signed [63:0] c0;
        logic signed [63:0] c1;
        logic signed [63:0] c2;
    } t_vec64;

    // status of the unit vector engine
    typedef struct packed {
        logic                     done;
        logic                     zero;
        logic signed [NRM_W-1:0]  ux;
        logic signed [NRM_W-1:0]  uy;
        logic signed [NRM_W-1:0]  uz;
    } t_uv_res;

endpackage

// ===== hw/rtl/vna_unit.sv =====
// iterative unit vector engine: normalize, sum of squares, square root, division
module vna_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  vna_pkg::t_vec64 i_vec,
    output vna_pkg::t_uv_res o_res
);
    import vna_pkg::*;

    typedef enum logic [6:0] {
        U_IDLE = 7'b0000001,
        U_NORM = 7'b0000010,
        U_SQ   = 7'b0000100,
        U_SQRT = 7'b0001000,
        U_DLD  = 7'b0010000,
        U_DIV  = 7'b0100000,
        U_DONE = 7'b1000000
    } t_ustate;

    t_ustate            r_state;
    logic [63:0]        r_m0, r_m1, r_m2;
    logic               r_neg0, r_neg1, r_neg2;
    logic [59:0]        r_prod;
    logic [63:0]        r_s;
    logic [63:0]        r_r;
    logic [63:0]        r_bit;
    logic [1:0]         r_sk;
    logic [1:0]         r_ci;
    logic [3:0]         r_k;
    logic [46:0]        r_rem;
    logic [15:0]        r_q;
    logic signed [15:0] r_u0, r_u1, r_u2;
    logic               r_zero;

    logic [63:0] mx;
    logic [63:0] mg0, mg1, mg2;
    logic [29:0] sq_in;
    logic [63:0] m_sel;
    logic        neg_sel;
    logic [30:0] len;
    logic [63:0] trial;
    logic [46:0] dsh;
    logic        ge;
    logic [15:0] qf;
    logic [15:0] qc;
    logic signed [15:0] uval;

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // magnitudes of the incoming vector
    assign mg0 = mag64(i_vec.c0);
    assign mg1 = mag64(i_vec.c1);
    assign mg2 = mag64(i_vec.c2);

    // largest magnitude for the normalizing shifts
    always_comb begin
        mx = r_m0;
        if (r_m1 > mx) mx = r_m1;
        if (r_m2 > mx) mx = r_m2;
    end

    // component selects for squaring and division
    always_comb begin
        case (r_sk)
            2'd0:    sq_in = r_m0[29:0];
            2'd1:    sq_in = r_m1[29:0];
            2'd2:    sq_in = r_m2[29:0];
            default: sq_in = '0;
        endcase
        case (r_ci)
            2'd0:    begin m_sel = r_m0; neg_sel = r_neg0; end
            2'd1:    begin m_sel = r_m1; neg_sel = r_neg1; end
            default: begin m_sel = r_m2; neg_sel = r_neg2; end
        endcase
    end

    // square root and division step logic
    assign len   = r_r[30:0];
    assign trial = r_r + r_bit;
    assign dsh   = 47'(len) << r_k;
    assign ge    = (r_rem >= dsh);
    assign qf    = {r_q[14:0], ge};
    assign qc    = (qf > 16'd16384) ? 16'd16384 : qf;
    assign uval  = neg_sel ? -$signed(qc) : $signed(qc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            case (r_state)
                U_IDLE: begin
                    if (i_go) begin
                        r_m0   <= mg0;
                        r_m1   <= mg1;
                        r_m2   <= mg2;
                        r_neg0 <= i_vec.c0[63];
                        r_neg1 <= i_vec.c1[63];
                        r_neg2 <= i_vec.c2[63];
                        r_zero <= (mg0 == '0) && (mg1 == '0) && (mg2 == '0);
                        if ((mg0 == '0) && (mg1 == '0) && (mg2 == '0)) begin
                            r_state <= U_DONE;
                        end else begin
                            r_state <= U_NORM;
                        end
                    end
                end
                // one bit of shift per cycle until the largest lies in [2^29, 2^30)
                U_NORM: begin
                    if (mx[63:30] != '0) begin
                        r_m0 <= r_m0 >> 1;
                        r_m1 <= r_m1 >> 1;
                        r_m2 <= r_m2 >> 1;
                    end else if (!mx[29]) begin
                        r_m0 <= r_m0 << 1;
                        r_m1 <= r_m1 << 1;
                        r_m2 <= r_m2 << 1;
                    end else begin
                        r_s     <= '0;
                        r_sk    <= '0;
                        r_state <= U_SQ;
                    end
                end
                // one square per cycle, each added in the cycle after
                U_SQ: begin
                    if (r_sk != 2'd3) r_prod <= sq_in * sq_in;
                    if (r_sk != 2'd0) r_s <= r_s + 64'(r_prod);
                    r_sk <= r_sk + 2'd1;
                    if (r_sk == 2'd3) begin
                        r_r     <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= U_SQRT;
                    end
                end
                // bit-pair square root, one result bit per cycle
                U_SQRT: begin
                    if (r_s >= trial) begin
                        r_s <= r_s - trial;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_ci    <= '0;
                        r_state <= U_DLD;
                    end
                end
                // rounded numerator for one component
                U_DLD: begin
                    r_rem   <= 47'({m_sel[29:0], 14'b0}) + 47'(len >> 1);
                    r_q     <= '0;
                    r_k     <= 4'd15;
                    r_state <= U_DIV;
                end
                // restoring division, one quotient bit per cycle
                U_DIV: begin
                    if (ge) r_rem <= r_rem - dsh;
                    r_q <= qf;
                    r_k <= r_k - 4'd1;
                    if (r_k == '0) begin
                        case (r_ci)
                            2'd0:    r_u0 <= uval;
                            2'd1:    r_u1 <= uval;
                            default: r_u2 <= uval;
                        endcase
                        if (r_ci == 2'd2) begin
                            r_state <= U_DONE;
                        end else begin
                            r_ci    <= r_ci + 2'd1;
                            r_state <= U_DLD;
                        end
                    end
                end
                U_DONE: begin
                    r_state <= U_IDLE;
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    assign o_res.done = (r_state == U_DONE);
    assign o_res.zero = r_zero;
    assign o_res.ux   = r_u0;
    assign o_res.uy   = r_u1;
    assign o_res.uz   = r_u2;

endmodule

// ===== hw/rtl/vertex_normal_accumulator.sv =====
// top level of the vertex normal accumulator
// Each item gives one result, shown for one cycle with o_strobe; the receiver cannot stall it.
// A vertex load keeps busy low. A face runs three vertex reads, six products on one
// multiplier of up to 31x31, then the shared unit vector engine (up to 32 normalizing
// shifts, the sum of squares, 32 square root steps and a division for each of the three
// components), then three read-modify-write passes over the accumulator memory.
// A normal read takes a memory read plus the unit vector engine.
// A clear sweeps the accumulator memory one entry a cycle. After reset the same sweep runs
// with busy high; configuration writes are taken.
module vertex_normal_accumulator #(
    parameter int VERTICES   = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  vna_pkg::t_cmd i_cmd,
    output logic          o_strobe,
    output vna_pkg::t_rsp o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import vna_pkg::*;

    localparam int AW   = $clog2(VERTICES);
    localparam int CW   = COORD_BITS;
    localparam int SH   = (CW > 30) ? (CW - 30) : 0;
    localparam int DW   = ((CW > 30) ? 30 : CW) + 1;
    localparam int PW   = 2 * DW;
    localparam int VW   = 3 * CW;
    localparam int SW3  = 3 * SUM_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(VERTICES - 1);

    typedef enum logic [9:0] {
        S_CLR    = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_VRD    = 10'b0000000100,
        S_EDGE   = 10'b0000001000,
        S_MUL    = 10'b0000010000,
        S_SRD    = 10'b0000100000,
        S_SWAIT  = 10'b0001000000,
        S_UNIT   = 10'b0010000000,
        S_ACC_RD = 10'b0100000000,
        S_ACC_WR = 10'b1000000000
    } t_state;

    // memories
    logic [VW-1:0]  vtx_mem [VERTICES];
    logic [SW3-1:0] sum_mem [VERTICES];

    t_state              r_state;
    t_cmd                r_cmd;
    logic [10:0]         r_count;
    logic [VW-1:0]       r_vrd;
    logic [SW3-1:0]      r_srd;
    logic [VW-1:0]       r_vtx [3];
    logic [1:0]          r_vk;
    logic signed [DW-1:0] r_e1 [3];
    logic signed [DW-1:0] r_e2 [3];
    logic [2:0]          r_mk;
    logic signed [PW-1:0] r_prod;
    logic signed [63:0]  r_cr [3];
    logic [1:0]          r_ck;
    t_uv_res             r_uv;
    logic                r_ugo;
    logic [AW-1:0]       r_caddr;
    logic                r_clr_emit;
    logic                r_strobe;
    t_rsp                r_rsp;

    logic                 acc;
    logic [16:0]          limit;
    logic                 idx_ok, face_ok;
    logic                 vwe;
    logic [AW-1:0]        vwaddr, vraddr;
    logic [VW-1:0]        vwdata;
    logic                 swe;
    logic [AW-1:0]        swaddr, sraddr;
    logic [SW3-1:0]       swdata;
    logic [9:0]           corner_sel, vcorner;
    logic signed [DW-1:0] op_a, op_b;
    t_vec64               uvec;
    t_uv_res              uv;

    function automatic logic [AW-1:0] addr_of(logic [9:0] idx);
        logic [16:0] ext;
        ext = 17'(idx);
        return ext[AW-1:0];
    endfunction

    function automatic logic [CW-1:0] coord_of(logic [23:0] f);
        logic [31:0] w;
        w = {8'b0, f};
        return w[CW-1:0];
    endfunction

    // edge component b - a, truncated toward zero for wide coordinates
    function automatic logic signed [DW-1:0] edge_of(logic [CW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] d;
        logic [CW:0] m;
        logic [CW:0] ms;
        logic [CW:0] r;
        d  = {b[CW-1], b} - {a[CW-1], a};
        m  = d[CW] ? (CW+1)'(-d) : d;
        ms = m >> SH;
        r  = d[CW] ? (CW+1)'(-ms) : ms;
        return r[DW-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s,
                                                 logic signed [NRM_W-1:0] u);
        logic [SUM_W:0] t;
        t = {s[SUM_W-1], s} + (SUM_W+1)'(u);
        if (t[SUM_W:SUM_W-1] == 2'b01) return {1'b0, {(SUM_W-1){1'b1}}};
        if (t[SUM_W:SUM_W-1] == 2'b10) return {1'b1, {(SUM_W-1){1'b0}}};
        return t[SUM_W-1:0];
    endfunction

    // index checks against the active vertex count
    assign limit   = (17'(r_count) < 17'(VERTICES)) ? 17'(r_count) : 17'(VERTICES);
    assign idx_ok  = 17'(i_cmd.vertex_index) < limit;
    assign face_ok = (17'(i_cmd.corner_a) < limit) && (17'(i_cmd.corner_b) < limit)
                   && (17'(i_cmd.corner_c) < limit);
    assign acc     = start && !busy;
    assign busy    = (r_state != S_IDLE);

    // corner selects for vertex reads and accumulator updates
    always_comb begin
        case (r_vk)
            2'd0:    vcorner = r_cmd.corner_a;
            2'd1:    vcorner = r_cmd.corner_b;
            default: vcorner = r_cmd.corner_c;
        endcase
        case (r_ck)
            2'd0:    corner_sel = r_cmd.corner_a;
            2'd1:    corner_sel = r_cmd.corner_b;
            default: corner_sel = r_cmd.corner_c;
        endcase
    end

    // vertex store ports
    assign vwe    = acc && (i_cmd.mode == MODE_LOAD) && idx_ok;
    assign vwaddr = addr_of(i_cmd.vertex_index);
    assign vwdata = {coord_of(i_cmd.pos_x), coord_of(i_cmd.pos_y), coord_of(i_cmd.pos_z)};
    assign vraddr = addr_of(vcorner);

    always_ff @(posedge i_clk) begin
        if (vwe) vtx_mem[vwaddr] <= vwdata;
        r_vrd <= vtx_mem[vraddr];
    end

    // accumulator store ports
    assign sraddr = (r_cmd.mode == MODE_READ) ? addr_of(r_cmd.vertex_index)
                                              : addr_of(corner_sel);
    always_comb begin
        swe    = 1'b0;
        swaddr = r_caddr;
        swdata = '0;
        if (r_state == S_CLR) begin
            swe = 1'b1;
        end else if (r_state == S_ACC_WR) begin
            swe    = 1'b1;
            swaddr = addr_of(corner_sel);
            swdata = {sat_add(r_srd[SW3-1:2*SUM_W], r_uv.ux),
                      sat_add(r_srd[2*SUM_W-1:SUM_W], r_uv.uy),
                      sat_add(r_srd[SUM_W-1:0], r_uv.uz)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (swe) sum_mem[swaddr] <= swdata;
        r_srd <= sum_mem[sraddr];
    end

    // multiplier operands for the cross product
    always_comb begin
        case (r_mk)
            3'd0:    begin op_a = r_e1[1]; op_b = r_e2[2]; end
            3'd1:    begin op_a = r_e1[2]; op_b = r_e2[1]; end
            3'd2:    begin op_a = r_e1[2]; op_b = r_e2[0]; end
            3'd3:    begin op_a = r_e1[0]; op_b = r_e2[2]; end
            3'd4:    begin op_a = r_e1[0]; op_b = r_e2[1]; end
            default: begin op_a = r_e1[1]; op_b = r_e2[0]; end
        endcase
    end

    // unit vector engine input: cross product or stored sum
    always_comb begin
        if (r_cmd.mode == MODE_READ) begin
            uvec.c0 = 64'($signed(r_srd[SW3-1:2*SUM_W]));
            uvec.c1 = 64'($signed(r_srd[2*SUM_W-1:SUM_W]));
            uvec.c2 = 64'($signed(r_srd[SUM_W-1:0]));
        end else begin
            uvec.c0 = r_cr[0];
            uvec.c1 = r_cr[1];
            uvec.c2 = r_cr[2];
        end
    end

    vna_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_ugo),
        .i_vec   (uvec),
        .o_res   (uv)
    );

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_caddr    <= '0;
            r_clr_emit <= 1'b0;
            r_strobe   <= 1'b0;
            r_ugo      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_ugo    <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_caddr <= r_caddr + 1'b1;
                    if (r_caddr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                        if (r_clr_emit) begin
                            r_strobe <= 1'b1;
                            r_rsp    <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                          status: ST_OK};
                        end
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.mode)
                            MODE_LOAD: begin
                                r_strobe <= 1'b1;
                                r_rsp    <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                              status: idx_ok ? ST_OK : ST_RANGE};
                            end
                            MODE_FACE: begin
                                if (face_ok) begin
                                    r_vk    <= '0;
                                    r_state <= S_VRD;
                                end else begin
                                    r_strobe <= 1'b1;
                                    r_rsp    <= '{normal_x: '0, normal_y: '0,
                                                  normal_z: '0, status: ST_RANGE};
                                end
                            end
                            MODE_READ: begin
                                if (idx_ok) begin
                                    r_state <= S_SRD;
                                end else begin
                                    r_strobe <= 1'b1;
                                    r_rsp    <= '{normal_x: '0, normal_y: '0,
                                                  normal_z: '0, status: ST_RANGE};
                                end
                            end
                            default: begin
                                r_caddr    <= '0;
                                r_clr_emit <= 1'b1;
                                r_state    <= S_CLR;
                            end
                        endcase
                    end
                end
                // read the three corners, data arriving in the cycle after its address
                S_VRD: begin
                    r_vk <= r_vk + 2'd1;
                    case (r_vk)
                        2'd1:    r_vtx[0] <= r_vrd;
                        2'd2:    r_vtx[1] <= r_vrd;
                        2'd3:    r_vtx[2] <= r_vrd;
                        default: ;
                    endcase
                    if (r_vk == 2'd3) r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_e1[0] <= edge_of(r_vtx[0][VW-1:2*CW], r_vtx[1][VW-1:2*CW]);
                    r_e1[1] <= edge_of(r_vtx[0][2*CW-1:CW], r_vtx[1][2*CW-1:CW]);
                    r_e1[2] <= edge_of(r_vtx[0][CW-1:0], r_vtx[1][CW-1:0]);
                    r_e2[0] <= edge_of(r_vtx[0][VW-1:2*CW], r_vtx[2][VW-1:2*CW]);
                    r_e2[1] <= edge_of(r_vtx[0][2*CW-1:CW], r_vtx[2][2*CW-1:CW]);
                    r_e2[2] <= edge_of(r_vtx[0][CW-1:0], r_vtx[2][CW-1:0]);
                    r_mk    <= '0;
                    r_state <= S_MUL;
                end
                // six products, each folded into its component in the cycle after
                S_MUL: begin
                    if (r_mk != 3'd6) r_prod <= op_a * op_b;
                    case (r_mk)
                        3'd1:    r_cr[0] <= 64'(r_prod);
                        3'd2:    r_cr[0] <= r_cr[0] - 64'(r_prod);
                        3'd3:    r_cr[1] <= 64'(r_prod);
                        3'd4:    r_cr[1] <= r_cr[1] - 64'(r_prod);
                        3'd5:    r_cr[2] <= 64'(r_prod);
                        3'd6:    r_cr[2] <= r_cr[2] - 64'(r_prod);
                        default: ;
                    endcase
                    r_mk <= r_mk + 3'd1;
                    if (r_mk == 3'd6) begin
                        r_ugo   <= 1'b1;
                        r_state <= S_UNIT;
                    end
                end
                S_SRD: begin
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    r_ugo   <= 1'b1;
                    r_state <= S_UNIT;
                end
                S_UNIT: begin
                    if (uv.done) begin
                        if (uv.zero) begin
                            r_strobe <= 1'b1;
                            r_rsp    <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                          status: ST_ZERO};
                            r_state  <= S_IDLE;
                        end else if (r_cmd.mode == MODE_READ) begin
                            r_strobe <= 1'b1;
                            r_rsp    <= '{normal_x: uv.ux, normal_y: uv.uy,
                                          normal_z: uv.uz, status: ST_OK};
                            r_state  <= S_IDLE;
                        end else begin
                            r_uv    <= uv;
                            r_ck    <= '0;
                            r_state <= S_ACC_RD;
                        end
                    end
                end
                S_ACC_RD: begin
                    r_state <= S_ACC_WR;
                end
                // saturating add written back in the same cycle
                S_ACC_WR: begin
                    r_ck <= r_ck + 2'd1;
                    if (r_ck == 2'd2) begin
                        r_strobe <= 1'b1;
                        r_rsp    <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                      status: ST_OK};
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_ACC_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT)) begin
            r_count <= pwdata[10:0];
        end
    end

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_VERTEX_COUNT) ? {21'b0, r_count} : '0;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
